// File: src/id3_pkg.sv
// Shared types and constants for the ID3v2 text frame extractor.
// Used by id3_parse_core, id3_out_stage and id3v2_text_frame_extractor.
package id3_pkg;

    localparam int unsigned OFS_W = 29;

    localparam logic [OFS_W-1:0] OFS_MAX = {OFS_W{1'b1}};

    localparam logic [7:0] HDR_LEN = 8'd10;

    localparam logic [7:0] MAGIC_0 = 8'h49;  // 'I'
    localparam logic [7:0] MAGIC_1 = 8'h44;  // 'D'
    localparam logic [7:0] MAGIC_2 = 8'h33;  // '3'

    localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
    localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
    localparam logic [31:0] ID_TALB = 32'h5441_4C42;

    localparam logic [7:0] SYNCHSAFE_VERSION = 8'd4;

    localparam logic [1:0] KIND_TITLE  = 2'd0;
    localparam logic [1:0] KIND_ARTIST = 2'd1;
    localparam logic [1:0] KIND_ALBUM  = 2'd2;

    localparam logic [1:0] ST_VALUE   = 2'd0;
    localparam logic [1:0] ST_TAG_END = 2'd1;
    localparam logic [1:0] ST_NO_TAG  = 2'd2;

    typedef enum logic [7:0] {
        PH_MAGIC   = 8'b0000_0001,
        PH_EXTSZ   = 8'b0000_0010,
        PH_SKIP    = 8'b0000_0100,
        PH_FHDR    = 8'b0000_1000,
        PH_ENC     = 8'b0001_0000,
        PH_BODY    = 8'b0010_0000,
        PH_DONE    = 8'b0100_0000,
        PH_ENDNEXT = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic [7:0] value_byte;
        logic [1:0] field_kind;
        logic       last_of_value;
        logic [1:0] status;
    } t_result;

endpackage

// File: src/id3_parse_core.sv
// Byte-serial tag parser: parse state registers and the per-byte next-state logic.
// Depends on id3_pkg.
module id3_parse_core import id3_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_data_byte,
    input  logic       i_start_of_file,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase            r_phase, n_phase, c_phase;
    logic [OFS_W-1:0]  r_pos, n_pos, c_pos;
    logic [OFS_W-1:0]  r_tag_end, n_tag_end, c_tag_end;
    logic [7:0]        r_version, n_version, c_version;
    logic              r_ext, n_ext, c_ext;
    logic [31:0]       r_acc, n_acc, c_acc;
    logic [31:0]       r_fid, n_fid, c_fid;
    logic [31:0]       r_left, n_left, c_left;
    logic [1:0]        r_kind, n_kind, c_kind;

    logic [31:0]       acc7, acc8, acc_sz, left_sat;
    logic [OFS_W-1:0]  tag_end_new;
    logic              kept;

    // start_of_file restarts the parse on this very byte
    always_comb begin
        if (i_start_of_file) begin
            c_phase   = PH_MAGIC;
            c_pos     = '0;
            c_tag_end = '0;
            c_version = '0;
            c_ext     = 1'b0;
            c_acc     = '0;
            c_fid     = '0;
            c_left    = '0;
            c_kind    = '0;
        end else begin
            c_phase   = r_phase;
            c_pos     = r_pos;
            c_tag_end = r_tag_end;
            c_version = r_version;
            c_ext     = r_ext;
            c_acc     = r_acc;
            c_fid     = r_fid;
            c_left    = r_left;
            c_kind    = r_kind;
        end
    end

    assign acc7        = {c_acc[24:0], i_data_byte[6:0]};
    assign acc8        = {c_acc[23:0], i_data_byte};
    assign acc_sz      = (c_version == SYNCHSAFE_VERSION) ? acc7 : acc8;
    assign left_sat    = c_left - {31'd0, (c_left != 32'd0)};
    assign tag_end_new = {1'b0, acc7[27:0]} + OFS_W'(HDR_LEN);

    always_comb begin
        n_phase     = c_phase;
        n_pos       = (c_pos == OFS_MAX) ? c_pos : c_pos + OFS_W'(1);
        n_tag_end   = c_tag_end;
        n_version   = c_version;
        n_ext       = c_ext;
        n_acc       = c_acc;
        n_fid       = c_fid;
        n_left      = c_left;
        n_kind      = c_kind;
        kept        = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;

        case (c_phase)
            PH_MAGIC: begin
                if ((c_pos == OFS_W'(0) && i_data_byte != MAGIC_0) ||
                    (c_pos == OFS_W'(1) && i_data_byte != MAGIC_1) ||
                    (c_pos == OFS_W'(2) && i_data_byte != MAGIC_2)) begin
                    o_res_valid = 1'b1;
                    o_res.status = ST_NO_TAG;
                    n_phase = PH_DONE;
                end else if (c_pos == OFS_W'(3)) begin
                    n_version = i_data_byte;
                end else if (c_pos == OFS_W'(5)) begin
                    n_ext = i_data_byte[6];
                end else if (c_pos >= OFS_W'(6)) begin
                    n_acc = acc7;
                    if (c_pos == OFS_W'(9)) begin
                        n_tag_end = tag_end_new;
                        n_acc     = '0;
                        if (c_ext && tag_end_new >= OFS_W'(14)) begin
                            n_phase = PH_EXTSZ;
                            n_left  = 32'd4;
                        end else begin
                            n_phase = PH_FHDR;
                            n_left  = 32'(HDR_LEN);
                            n_fid   = '0;
                        end
                    end
                end
            end
            PH_EXTSZ: begin
                n_acc  = acc_sz;
                n_left = c_left - 32'd1;
                if (c_left == 32'd1) begin
                    if (acc_sz < 32'd4 ||
                        ({1'b0, acc_sz} + 33'd20) > {4'd0, c_tag_end}) begin
                        n_phase = PH_ENDNEXT;
                    end else if (acc_sz == 32'd4) begin
                        n_phase = PH_FHDR;
                        n_left  = 32'(HDR_LEN);
                        n_fid   = '0;
                        n_acc   = '0;
                    end else begin
                        n_phase = PH_SKIP;
                        n_left  = acc_sz - 32'd4;
                    end
                end
            end
            PH_SKIP: begin
                n_left = left_sat;
                if (left_sat == 32'd0) begin
                    n_phase = PH_FHDR;
                    n_left  = 32'(HDR_LEN);
                    n_fid   = '0;
                    n_acc   = '0;
                end
            end
            PH_FHDR: begin
                if (c_left == 32'(HDR_LEN) &&
                    (({1'b0, c_pos} + 30'(HDR_LEN)) > {1'b0, c_tag_end} ||
                     i_data_byte == 8'd0)) begin
                    // header does not fit, or padding reached
                    o_res_valid = 1'b1;
                    o_res.status = ST_TAG_END;
                    n_phase = PH_DONE;
                end else begin
                    if (c_left > 32'd6) begin
                        n_fid = {c_fid[23:0], i_data_byte};
                    end else if (c_left > 32'd2) begin
                        n_acc = acc_sz;
                    end
                    n_left = c_left - 32'd1;
                    if (c_left == 32'd1) begin
                        // frame size is complete in c_acc, ID in c_fid
                        if (({4'd0, c_pos} + 33'd1 + {1'b0, c_acc}) >
                            {4'd0, c_tag_end}) begin
                            o_res_valid = 1'b1;
                            o_res.status = ST_TAG_END;
                            n_phase = PH_DONE;
                        end else begin
                            kept = 1'b1;
                            if (c_fid == ID_TIT2) begin
                                n_kind = KIND_TITLE;
                            end else if (c_fid == ID_TPE1) begin
                                n_kind = KIND_ARTIST;
                            end else if (c_fid == ID_TALB) begin
                                n_kind = KIND_ALBUM;
                            end else begin
                                kept = 1'b0;
                            end
                            if (c_acc <= 32'd1) begin
                                kept = 1'b0;
                            end
                            if (c_acc == 32'd0) begin
                                n_phase = PH_FHDR;
                                n_left  = 32'(HDR_LEN);
                                n_fid   = '0;
                                n_acc   = '0;
                            end else if (kept) begin
                                n_phase = PH_ENC;
                                n_left  = c_acc - 32'd1;
                            end else begin
                                n_phase = PH_SKIP;
                                n_left  = c_acc;
                            end
                        end
                    end
                end
            end
            PH_ENC: begin
                if (c_left != 32'd0) begin
                    n_phase = PH_BODY;
                end else begin
                    n_phase = PH_FHDR;
                    n_left  = 32'(HDR_LEN);
                    n_fid   = '0;
                    n_acc   = '0;
                end
            end
            PH_BODY: begin
                o_res_valid         = 1'b1;
                o_res.value_byte    = i_data_byte;
                o_res.field_kind    = c_kind;
                o_res.last_of_value = (c_left == 32'd1);
                o_res.status        = ST_VALUE;
                n_left = left_sat;
                if (left_sat == 32'd0) begin
                    n_phase = PH_FHDR;
                    n_left  = 32'(HDR_LEN);
                    n_fid   = '0;
                    n_acc   = '0;
                end
            end
            PH_ENDNEXT: begin
                o_res_valid = 1'b1;
                o_res.status = ST_TAG_END;
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = c_phase;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_MAGIC;
            r_pos     <= '0;
            r_tag_end <= '0;
            r_version <= '0;
            r_ext     <= 1'b0;
            r_acc     <= '0;
            r_fid     <= '0;
            r_left    <= '0;
            r_kind    <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_tag_end <= n_tag_end;
            r_version <= n_version;
            r_ext     <= n_ext;
            r_acc     <= n_acc;
            r_fid     <= n_fid;
            r_left    <= n_left;
            r_kind    <= n_kind;
        end
    end

endmodule

// File: src/id3_out_stage.sv
// Result register between the parse core and the output channel.
// Depends on id3_pkg.
module id3_out_stage import id3_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  logic    i_res_valid,
    input  t_result i_res,
    input  logic    i_out_ready,
    output logic    o_slot_free,
    output logic    o_out_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_slot_free = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_slot_free) begin
            r_valid <= i_load && i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_slot_free) begin
            r_res <= i_res;
        end
    end

endmodule

// File: src/id3v2_text_frame_extractor.sv
// Top level of the ID3v2 text frame extractor: input register, parse core, result register.
// Depends on id3_pkg, id3_parse_core, id3_out_stage.
//
//   channel | valid       | ready        | payload
//   --------+-------------+--------------+---------------------------------------------------
//   in      | i_in_valid  | o_in_ready   | i_data_byte, i_start_of_file
//   out     | o_out_valid | i_out_ready  | o_value_byte, o_field_kind, o_last_of_value, o_status
//
// One byte per cycle sustained while the output is not stalled.
// A registered byte is parsed when the result slot is free, all state updates in that cycle.
// Reset (i_rst_n low at a clock edge) returns to waiting for the ID3 magic at offset zero.
// A stalled output holds its result; the input register then holds one byte and
// o_in_ready drops until the result is taken.
module id3v2_text_frame_extractor import id3_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_start_of_file,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_value_byte,
    output logic [1:0] o_field_kind,
    output logic       o_last_of_value,
    output logic [1:0] o_status
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_sof;
    logic       step, slot_free, res_valid;
    t_result    res, out_res;
    logic       r_ended;

    assign step       = r_in_valid && slot_free;
    assign o_in_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_sof  <= i_start_of_file;
        end
    end

    id3_parse_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_data_byte     (r_in_byte),
        .i_start_of_file (r_in_sof),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    id3_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_out_ready (i_out_ready),
        .o_slot_free (slot_free),
        .o_out_valid (o_out_valid),
        .o_res       (out_res)
    );

    assign o_value_byte    = out_res.value_byte;
    assign o_field_kind    = out_res.field_kind;
    assign o_last_of_value = out_res.last_of_value;
    assign o_status        = out_res.status;

    // set once a status transaction goes out, cleared when a new file starts parsing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ended <= 1'b0;
        end else if (step && r_in_sof) begin
            r_ended <= 1'b0;
        end else if (o_out_valid && i_out_ready && o_status != ST_VALUE) begin
            r_ended <= 1'b1;
        end
    end

`ifndef ASSERT_OFF
    a_silent_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ended |-> !o_out_valid)
        else $error("result after tag end without new file");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_VALUE) |->
            (o_value_byte == 8'd0 && o_field_kind == 2'd0 && !o_last_of_value))
        else $error("status transaction carries value fields");

    a_codes_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status != 2'd3 && o_field_kind != 2'd3))
        else $error("illegal status or field kind code");
`endif

endmodule

// File: bench/tb_id3v2_text_frame_extractor.sv
// Testbench for id3v2_text_frame_extractor: streams whole files, with and without an ID3v2 tag,
// byte per transaction, and compares every value and status result with a predictor of the tag parser.
// Depends on id3_pkg and the RTL in src/.
module tb_id3v2_text_frame_extractor;
    timeunit 1ns;
    timeprecision 1ps;
    import id3_pkg::*;

    localparam int          RANDOM_BYTES = 550;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          IDLE_PCT     = 13;
    localparam int          MAX_PRINTS   = 100;
    localparam int unsigned EXT_SIZE_LEN = 4;
    localparam logic [31:0] ID_COMM      = 32'h434F_4D4D;
    localparam logic [7:0]  PLAIN_VER    = 8'd3;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_start_of_file = 1'b0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_value_byte;
    logic [1:0] o_field_kind;
    logic       o_last_of_value;
    logic [1:0] o_status;

    id3v2_text_frame_extractor DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_start_of_file (i_start_of_file),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_value_byte    (o_value_byte),
        .o_field_kind    (o_field_kind),
        .o_last_of_value (o_last_of_value),
        .o_status        (o_status)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // parser shadow state
    t_phase      pr_phase = PH_MAGIC;
    logic [28:0] pr_ofs = '0;
    logic [28:0] pr_tag_end = '0;
    logic [7:0]  pr_version = '0;
    logic        pr_ext_flag = 1'b0;
    logic [31:0] pr_acc = '0;
    logic [31:0] pr_frame_id = '0;
    logic [31:0] pr_left = '0;
    logic [1:0]  pr_kind = '0;
    logic        pr_kept = 1'b0;

    t_result     pending_results[$];
    logic [7:0]  file_bytes[$];
    int          error_count = 0;
    int          parsed_count = 0;
    int          cycle_count = 0;
    bit          gaps_on = 1'b1;

    function void clear_parser();
        pr_phase    = PH_MAGIC;
        pr_ofs      = '0;
        pr_tag_end  = '0;
        pr_version  = '0;
        pr_ext_flag = 1'b0;
        pr_acc      = '0;
        pr_frame_id = '0;
        pr_left     = '0;
        pr_kind     = '0;
        pr_kept     = 1'b0;
    endfunction

    function void start_frame();
        pr_phase    = PH_FHDR;
        pr_left     = 32'(HDR_LEN);
        pr_frame_id = '0;
        pr_acc      = '0;
    endfunction

    function logic [31:0] next_size(logic [31:0] acc, logic [7:0] b);
        return (pr_version == SYNCHSAFE_VERSION) ? {acc[24:0], b[6:0]} : {acc[23:0], b};
    endfunction

    // Advance the shadow parser by one byte, queue the result it produces.
    function void parse_expected(logic [7:0] b, logic sof);
        logic [28:0]     pos;
        logic [31:0]     fsz;
        longint unsigned posw;
        longint unsigned endw;
        t_result         r;
        bit              emit;
        if (sof)
            clear_parser();
        pos  = pr_ofs;
        posw = 64'(pos);
        endw = 64'(pr_tag_end);
        r    = '0;
        emit = 1'b0;
        if (pr_phase != PH_DONE)
            parsed_count++;
        case (pr_phase)
            PH_MAGIC: begin
                if ((pos == 0 && b != MAGIC_0) || (pos == 1 && b != MAGIC_1) ||
                    (pos == 2 && b != MAGIC_2)) begin
                    r.status = ST_NO_TAG;
                    emit     = 1'b1;
                    pr_phase = PH_DONE;
                end else if (pos == 3) begin
                    pr_version = b;
                end else if (pos == 5) begin
                    pr_ext_flag = b[6];
                end else if (pos >= 6) begin
                    pr_acc = {pr_acc[24:0], b[6:0]};
                    if (pos == 9) begin
                        pr_tag_end = {1'b0, pr_acc[27:0]} + 29'(HDR_LEN);
                        pr_acc     = '0;
                        if (pr_ext_flag && pr_tag_end >= HDR_LEN + EXT_SIZE_LEN) begin
                            pr_phase = PH_EXTSZ;
                            pr_left  = EXT_SIZE_LEN;
                        end else begin
                            start_frame();
                        end
                    end
                end
            end
            PH_EXTSZ: begin
                pr_acc = next_size(pr_acc, b);
                pr_left--;
                if (pr_left == 0) begin
                    // first frame header must fit behind the extended header
                    if (pr_acc < EXT_SIZE_LEN || longint'(pr_acc) + 2 * HDR_LEN > endw)
                        pr_phase = PH_ENDNEXT;
                    else if (pr_acc == EXT_SIZE_LEN)
                        start_frame();
                    else begin
                        pr_phase = PH_SKIP;
                        pr_left  = pr_acc - EXT_SIZE_LEN;
                    end
                end
            end
            PH_SKIP: begin
                if (pr_left > 0)
                    pr_left--;
                if (pr_left == 0)
                    start_frame();
            end
            PH_FHDR: begin
                if (pr_left == HDR_LEN && (posw + HDR_LEN > endw || b == 8'h00)) begin
                    r.status = ST_TAG_END;
                    emit     = 1'b1;
                    pr_phase = PH_DONE;
                end else begin
                    if (pr_left > 6)
                        pr_frame_id = {pr_frame_id[23:0], b};
                    else if (pr_left > 2)
                        pr_acc = next_size(pr_acc, b);
                    pr_left--;
                    if (pr_left == 0) begin
                        fsz = pr_acc;
                        if (posw + 1 + fsz > endw) begin
                            r.status = ST_TAG_END;
                            emit     = 1'b1;
                            pr_phase = PH_DONE;
                        end else begin
                            pr_kept = 1'b1;
                            case (pr_frame_id)
                                ID_TIT2: pr_kind = KIND_TITLE;
                                ID_TPE1: pr_kind = KIND_ARTIST;
                                ID_TALB: pr_kind = KIND_ALBUM;
                                default: pr_kept = 1'b0;
                            endcase
                            if (fsz <= 1)
                                pr_kept = 1'b0;
                            if (fsz == 0) begin
                                start_frame();
                            end else if (pr_kept) begin
                                pr_phase = PH_ENC;
                                pr_left  = fsz - 1;
                            end else begin
                                pr_phase = PH_SKIP;
                                pr_left  = fsz;
                            end
                        end
                    end
                end
            end
            PH_ENC: begin
                if (pr_left > 0)
                    pr_phase = PH_BODY;
                else
                    start_frame();
            end
            PH_BODY: begin
                r.value_byte    = b;
                r.field_kind    = pr_kind;
                r.last_of_value = (pr_left == 1);
                r.status        = ST_VALUE;
                emit            = 1'b1;
                if (pr_left > 0)
                    pr_left--;
                if (pr_left == 0)
                    start_frame();
            end
            PH_ENDNEXT: begin
                r.status = ST_TAG_END;
                emit     = 1'b1;
                pr_phase = PH_DONE;
            end
            default: ;
        endcase
        if (pr_ofs != OFS_MAX)
            pr_ofs++;
        if (emit)
            pending_results.push_back(r);
    endfunction

    task automatic report_mismatch(string what, int unsigned want, int unsigned got);
        if (error_count < MAX_PRINTS)
            $display("%0t ns: %s: expected %0d, got %0d", $realtime, what, want, got);
        error_count++;
    endtask

    // sends one byte; called and returns at a falling edge
    task automatic send_byte(logic [7:0] b, logic sof);
        if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_data_byte     <= b;
        i_start_of_file <= sof;
        do @(posedge i_clk); while (!o_in_ready);
        parse_expected(b, sof);
        @(negedge i_clk);
    endtask

    task automatic send_file();
        foreach (file_bytes[k])
            send_byte(file_bytes[k], k == 0);
        file_bytes.delete();
    endtask

    always @(negedge i_clk)
        i_out_ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transaction with none pending, status", 0,
                                32'(o_status));
            end else begin
                want = pending_results.pop_front();
                if (o_status != want.status)
                    report_mismatch("status", 32'(want.status), 32'(o_status));
                if (o_value_byte != want.value_byte)
                    report_mismatch("value_byte", 32'(want.value_byte), 32'(o_value_byte));
                if (o_field_kind != want.field_kind)
                    report_mismatch("field_kind", 32'(want.field_kind), 32'(o_field_kind));
                if (o_last_of_value != want.last_of_value)
                    report_mismatch("last_of_value", 32'(want.last_of_value),
                                    32'(o_last_of_value));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---- file building ----

    // top bit is noise; the parser masks it off
    function logic [7:0] synchsafe_byte(int unsigned v, int unsigned k);
        return {1'($urandom_range(1)), 7'(v >> (7 * (3 - k)))};
    endfunction

    function void put_random(int unsigned n);
        repeat (n) file_bytes.push_back(8'($urandom_range(255)));
    endfunction

    function void put_size(logic [7:0] ver, int unsigned v);
        for (int k = 0; k < 4; k++)
            file_bytes.push_back(ver == SYNCHSAFE_VERSION ? synchsafe_byte(v, k)
                                                          : 8'(v >> (8 * (3 - k))));
    endfunction

    // size bytes are left zero until set_tag_size
    function void put_tag_header(logic [7:0] ver, bit ext);
        logic [7:0] fl;
        fl    = 8'($urandom_range(255));
        fl[6] = ext;
        file_bytes.push_back(MAGIC_0);
        file_bytes.push_back(MAGIC_1);
        file_bytes.push_back(MAGIC_2);
        file_bytes.push_back(ver);
        file_bytes.push_back(8'($urandom_range(255)));
        file_bytes.push_back(fl);
        repeat (4) file_bytes.push_back(8'h00);
    endfunction

    function void set_tag_size(int unsigned v);
        for (int k = 0; k < 4; k++)
            file_bytes[6 + k] = synchsafe_byte(v, k);
    endfunction

    function void put_frame_header(logic [31:0] id, logic [7:0] ver, int unsigned size);
        for (int k = 0; k < 4; k++)
            file_bytes.push_back(id[31 - 8 * k -: 8]);
        put_size(ver, size);
        put_random(2);
    endfunction

    function void build_random_file();
        logic [7:0]  ver;
        logic [31:0] id;
        bit          ext;
        int unsigned ext_sz;
        int unsigned fsz;
        int unsigned tag_sz;
        int unsigned cut;
        file_bytes.delete();
        // plain noise, usually no tag at all
        if ($urandom_range(99) < 8) begin
            put_random($urandom_range(1, 12));
            if ($urandom_range(1))
                file_bytes[0] = MAGIC_0;
            return;
        end
        case ($urandom_range(5))
            0, 1:    ver = PLAIN_VER;
            2, 3:    ver = SYNCHSAFE_VERSION;
            4:       ver = 8'd2;
            default: ver = 8'($urandom_range(255));
        endcase
        ext = ($urandom_range(3) == 0);
        put_tag_header(ver, ext);
        if (ext) begin
            case ($urandom_range(7))
                0:       ext_sz = $urandom_range(3);
                1:       ext_sz = $urandom_range(9, 40);
                default: ext_sz = $urandom_range(4, 8);
            endcase
            put_size(ver, ext_sz);
            if (ext_sz > EXT_SIZE_LEN)
                put_random(ext_sz - EXT_SIZE_LEN);
        end
        repeat ($urandom_range(4)) begin
            case ($urandom_range(9))
                0, 1:    id = ID_TIT2;
                2, 3:    id = ID_TPE1;
                4, 5:    id = ID_TALB;
                6:       id = {ID_TIT2[31:8], 8'($urandom_range(255))};
                default: id = {8'($urandom_range(1, 255)), 24'($urandom)};
            endcase
            fsz = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 7);
            put_frame_header(id, ver, fsz);
            put_random(fsz);
        end
        repeat ($urandom_range(3)) file_bytes.push_back(8'h00);
        tag_sz = file_bytes.size() - HDR_LEN;
        case ($urandom_range(9))
            0:       tag_sz += $urandom_range(1, 12);
            1:       tag_sz = (tag_sz > 12) ? tag_sz - $urandom_range(1, 12) : 0;
            default: ;
        endcase
        set_tag_size(tag_sz);
        put_random($urandom_range(4));
        if ($urandom_range(11) == 0)
            file_bytes[$urandom_range(file_bytes.size() - 1)] = 8'($urandom_range(255));
        if ($urandom_range(19) == 0) begin
            cut = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > cut)
                void'(file_bytes.pop_back());
        end
    endfunction

    // ---- tests ----

    task automatic test_missing_magic();
        file_bytes = '{8'hFF, MAGIC_0, MAGIC_1};
        send_file();
        file_bytes = '{MAGIC_0, 8'h00, MAGIC_2, 8'h03};
        send_file();
        file_bytes = '{MAGIC_0, MAGIC_1, 8'hFF, MAGIC_2};
        send_file();
    endtask

    task automatic test_text_frames();
        put_tag_header(PLAIN_VER, 1'b0);
        put_frame_header(ID_TIT2, PLAIN_VER, 5);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'h41);
        file_bytes.push_back(8'h7F);
        put_frame_header(ID_TPE1, PLAIN_VER, 2);
        put_random(2);
        put_frame_header(ID_COMM, PLAIN_VER, 3);
        put_random(3);
        put_frame_header(ID_TALB, PLAIN_VER, 1);  // encoding byte only
        put_random(1);
        put_frame_header(ID_TIT2, PLAIN_VER, 0);
        put_frame_header(ID_TALB, PLAIN_VER, 3);
        put_random(3);
        file_bytes.push_back(8'h00);  // padding ends the tag
        file_bytes.push_back(8'h00);
        set_tag_size(file_bytes.size() - HDR_LEN);
        put_random(3);
        send_file();
    endtask

    task automatic test_v4_ext_header();
        put_tag_header(SYNCHSAFE_VERSION, 1'b1);
        put_size(SYNCHSAFE_VERSION, 6);
        put_random(2);
        put_frame_header(ID_TPE1, SYNCHSAFE_VERSION, 3);
        put_random(3);
        put_frame_header(ID_TALB, SYNCHSAFE_VERSION, 129);  // size spans two synchsafe bytes
        put_random(129);
        set_tag_size(file_bytes.size() - HDR_LEN);
        put_random(4);  // tag full: next header cannot fit
        send_file();
    endtask

    task automatic test_ext_header_limits();
        put_tag_header(PLAIN_VER, 1'b1);
        put_size(PLAIN_VER, EXT_SIZE_LEN);
        put_frame_header(ID_TIT2, PLAIN_VER, 2);
        put_random(2);
        set_tag_size(file_bytes.size() - HDR_LEN);
        put_random(2);
        send_file();
        // extended size too small to cover its own size field
        put_tag_header(PLAIN_VER, 1'b1);
        put_size(PLAIN_VER, 2);
        put_random(12);
        set_tag_size(20);
        send_file();
        // extended header runs past the tag
        put_tag_header(PLAIN_VER, 1'b1);
        put_size(PLAIN_VER, 100);
        put_random(6);
        set_tag_size(30);
        send_file();
        // flagged, but the size field itself does not fit
        put_tag_header(PLAIN_VER, 1'b1);
        put_random(4);
        set_tag_size(2);
        send_file();
        // size field fits, no room left for a frame header
        put_tag_header(SYNCHSAFE_VERSION, 1'b1);
        put_size(SYNCHSAFE_VERSION, EXT_SIZE_LEN);
        put_random(2);
        set_tag_size(EXT_SIZE_LEN);
        send_file();
    endtask

    task automatic test_frame_overrun();
        put_tag_header(PLAIN_VER, 1'b0);
        put_frame_header(ID_TIT2, PLAIN_VER, 32'hFFFF_FFFF);
        put_random(8);
        set_tag_size(30);
        send_file();
        put_tag_header(SYNCHSAFE_VERSION, 1'b0);
        put_frame_header(ID_TALB, SYNCHSAFE_VERSION, 6);  // one byte past the end
        put_random(6);
        set_tag_size(15);
        send_file();
        put_tag_header(PLAIN_VER, 1'b0);
        put_frame_header(ID_TPE1, PLAIN_VER, 3);
        put_random(3);
        file_bytes.push_back(8'h00);
        put_random(2);
        set_tag_size(28'hFFF_FFFF);
        send_file();
    endtask

    task automatic test_restart();
        put_tag_header(PLAIN_VER, 1'b0);
        put_frame_header(ID_TIT2, PLAIN_VER, 6);
        put_random(3);  // cut off inside the value
        set_tag_size(16);
        send_file();
        put_tag_header(SYNCHSAFE_VERSION, 1'b0);
        put_frame_header(ID_TPE1, SYNCHSAFE_VERSION, 2);
        put_random(2);
        set_tag_size(file_bytes.size() - HDR_LEN);
        put_random(1);
        send_file();
        file_bytes = '{8'h00};
        send_file();
    endtask

    task automatic test_random_files();
        int start;
        int done;
        start = parsed_count;
        done  = 0;
        while (done < RANDOM_BYTES) begin
            // quiet window: no gaps, no stalls
            gaps_on = (done < RANDOM_BYTES * 2 / 5) || (done > RANDOM_BYTES * 3 / 5);
            build_random_file();
            send_file();
            done = parsed_count - start;
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_missing_magic();
        test_text_frames();
        test_v4_ext_header();
        test_ext_header_limits();
        test_frame_overrun();
        test_restart();
        test_random_files();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: id3v2_text_frame_extractor.f
src/id3_pkg.sv
src/id3_parse_core.sv
src/id3_out_stage.sv
src/id3v2_text_frame_extractor.sv
bench/tb_id3v2_text_frame_extractor.sv
